FILE: rtl/core/mexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mexp_pkg;

    localparam int unsigned FIELD_BITS = 63;

    typedef struct packed {
        logic                  operation;
        logic [FIELD_BITS-1:0] base_value;
        logic [FIELD_BITS-1:0] exponent_value;
        logic [FIELD_BITS-1:0] modulus_value;
    } t_req;

    typedef struct packed {
        logic [FIELD_BITS-1:0] power_result;
        logic                  is_residue;
    } t_rsp;

    typedef enum logic [1:0] {
        MUL_SQUARE = 2'b01,
        MUL_BASE   = 2'b10
    } t_mul_sel;

    // Datapath commands from the controller.
    typedef struct packed {
        logic     load;
        logic     red_start;
        logic     red_step;
        logic     prep_done;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     mul_step;
        logic     mul_done;
        logic     bit_next;
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic trivial;
        logic red_last;
        logic mul_last;
        logic exp_bit;
        logic bit_last;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/core/mexp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mexp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire mexp_pkg::t_sts i_sts,
    output logic               o_busy,
    output logic               o_done,
    output mexp_pkg::t_cmd     o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_RED   = 7'b0000100,
        S_SQ    = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = mexp_pkg::MUL_SQUARE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.trivial) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.red_start = 1'b1;
                    n_state         = S_RED;
                end
            end
            S_RED: begin
                o_cmd.red_step = 1'b1;
                if (i_sts.red_last) begin
                    o_cmd.prep_done = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    o_cmd.mul_done = 1'b1;
                    if (i_sts.exp_bit) begin
                        o_cmd.mul_start = 1'b1;
                        n_state         = S_MUL;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_sel  = mexp_pkg::MUL_BASE;
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    o_cmd.mul_done = 1'b1;
                    n_state        = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.bit_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.bit_next  = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_SQ;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held for two cycles");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("start not taken");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("not idle after done");

endmodule
`default_nettype wire

FILE: rtl/core/mexp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module mexp_dp #(
    parameter int unsigned OPERAND_BITS = 63
) (
    input  wire logic           i_clk,
    input  wire mexp_pkg::t_req i_req,
    input  wire mexp_pkg::t_cmd i_cmd,
    output mexp_pkg::t_sts      o_sts,
    output mexp_pkg::t_rsp      o_rsp
);

    localparam int unsigned W  = OPERAND_BITS;
    localparam int unsigned CW = $clog2(W + 1);
    localparam int unsigned BW = $clog2(W);

    logic [W-1:0]  r_m, r_e, r_b, r_acc, r_x, r_y, r_p;
    logic [W-1:0]  r_red;
    logic [W-1:0]  r_rbase;
    logic          r_op, r_trivial, r_tres, r_m2;
    logic [CW-1:0] r_cnt;
    logic [BW-1:0] r_bit;

    // Operands masked to the configured width.
    logic [W-1:0] w_base, w_exp, w_mod, w_em1;
    assign w_base = i_req.base_value[W-1:0];
    assign w_mod  = i_req.modulus_value[W-1:0];
    assign w_em1  = (w_mod - W'(1)) >> 1;
    assign w_exp  = i_req.operation ? w_em1 : i_req.exponent_value[W-1:0];

    // One shift-subtract step of a restoring remainder, one step of
    // shift-add modular multiply; both in W+1 bits to keep the carry.
    logic [W:0] w_rsh, w_psh, w_pad, w_msh;
    logic [W-1:0] w_p1, w_p2, w_red_nx;
    assign w_rsh    = {r_red, r_rbase[W-1]};
    assign w_red_nx = (w_rsh >= w_msh) ? W'(w_rsh - w_msh) : w_rsh[W-1:0];
    assign w_msh    = {1'b0, r_m};
    assign w_psh    = {r_p, 1'b0};
    assign w_p1  = (w_psh >= w_msh) ? W'(w_psh - w_msh) : w_psh[W-1:0];
    assign w_pad = {1'b0, w_p1} + {1'b0, r_x};
    assign w_p2  = r_y[W-1] ? ((w_pad >= w_msh) ? W'(w_pad - w_msh) : w_pad[W-1:0])
                            : w_p1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_req.operation;
            r_m     <= w_mod;
            r_e     <= w_exp;
            r_rbase <= w_base;
            r_m2    <= (w_mod == W'(2));
            if (i_req.operation) begin
                r_trivial <= (w_mod == '0) || (w_em1 == '0);
                r_tres    <= (w_mod != '0);
            end else begin
                r_trivial <= (w_exp == '0) || (w_mod == '0);
                r_tres    <= (w_exp == '0);
            end
        end
        if (i_cmd.red_start) begin
            r_red <= '0;
            r_cnt <= CW'(W);
        end
        if (i_cmd.red_step) begin
            r_red   <= w_red_nx;
            r_rbase <= r_rbase << 1;
            r_cnt   <= r_cnt - CW'(1);
        end
        if (i_cmd.prep_done) begin
            // base mod m, or m - (r mod m) for the residue test (may equal m).
            r_b   <= r_op ? W'(r_m - w_red_nx) : w_red_nx;
            r_acc <= (r_m == W'(1)) ? '0 : W'(1);
            r_bit <= BW'(W - 1);
        end
        if (i_cmd.mul_start) begin
            r_p   <= '0;
            r_cnt <= CW'(W);
            r_x   <= i_cmd.prep_done ? ((r_m == W'(1)) ? '0 : W'(1)) : r_acc;
            r_y   <= i_cmd.prep_done ? ((r_m == W'(1)) ? '0 : W'(1)) : r_acc;
        end else if (i_cmd.mul_done && (i_cmd.mul_sel == mexp_pkg::MUL_SQUARE)) begin
            r_p   <= '0;
            r_cnt <= CW'(W);
        end
        if (i_cmd.mul_step && !i_cmd.mul_done) begin
            r_p   <= w_p2;
            r_y   <= r_y << 1;
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.mul_done) begin
            r_acc <= w_p2;
            // Square leads into acc*b: x = b, y = new acc.
            if (i_cmd.mul_sel == mexp_pkg::MUL_SQUARE) begin
                r_x <= r_b;
                r_y <= w_p2;
                r_p <= '0;
            end
        end
        if (i_cmd.bit_next) begin
            r_bit <= r_bit - BW'(1);
            r_x   <= r_acc;
            r_y   <= r_acc;
        end
    end

    assign o_sts.trivial  = r_trivial;
    assign o_sts.red_last = (r_cnt == CW'(1));
    assign o_sts.mul_last = (r_cnt == CW'(1));
    assign o_sts.exp_bit  = r_e[r_bit];
    assign o_sts.bit_last = (r_bit == '0);

    always_comb begin
        o_rsp = '0;
        if (r_trivial) begin
            o_rsp.power_result = mexp_pkg::FIELD_BITS'(r_tres);
            o_rsp.is_residue   = r_op && r_tres;
        end else begin
            o_rsp.power_result = mexp_pkg::FIELD_BITS'(r_acc);
            o_rsp.is_residue   = r_op && (r_m2 || (r_acc == W'(1)));
        end
    end

    a_mod_stable: assert property (@(posedge i_clk)
        (i_cmd.mul_step && !i_cmd.load) |=> $stable(r_m))
        else $error("modulus moved during multiply");
    a_acc_below: assert property (@(posedge i_clk)
        i_cmd.mul_done |=> (r_acc < r_m) || (r_m == '0))
        else $error("accumulator not reduced");
    a_red_below: assert property (@(posedge i_clk)
        i_cmd.red_step |=> (r_red < r_m) || (r_m == '0))
        else $error("remainder not reduced");

endmodule
`default_nettype wire

FILE: rtl/core/modular_exponentiation_qr_test.sv
`timescale 1ns / 1ps
// The result follows the start transfer through load, a restoring reduction of the base, then
// for each of the W = OPERAND_BITS exponent bits a square and, for a set bit, a multiply by the base.
// One shift-add modular multiply step per cycle; trivial requests (zero exponent
// or modulus, residue test with modulus one or two) go from load straight to done.
// Throughput: one request at a time; busy falls the cycle after the result strobe,
// which pulses one cycle; the receiver cannot stall. Reset: synchronous active low.
`default_nettype none
module modular_exponentiation_qr_test #(
    parameter int unsigned OPERAND_BITS = 63
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire mexp_pkg::t_req i_req,
    output logic                busy,
    output logic                o_done,
    output mexp_pkg::t_rsp      o_rsp
);

    mexp_pkg::t_cmd w_cmd;
    mexp_pkg::t_sts w_sts;

    mexp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    mexp_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .i_clk (i_clk),
        .i_req (i_req),
        .i_cmd (w_cmd),
        .o_sts (w_sts),
        .o_rsp (o_rsp)
    );

endmodule
`default_nettype wire
